// ===== rtl/fpa_pkg.sv =====
// ---------------------------------------------------------------------------
// Fixed-point ALU package
// Beat types, opcodes and the sideband record that travels beside the
// divider pipeline.
// ---------------------------------------------------------------------------
package fpa_pkg;

   typedef enum logic [3:0] {
      OP_ADD      = 4'd0,
      OP_SUB      = 4'd1,
      OP_MUL      = 4'd2,
      OP_DIV      = 4'd3,
      OP_INC      = 4'd4,
      OP_DEC      = 4'd5,
      OP_MIN      = 4'd6,
      OP_MAX      = 4'd7,
      OP_TO_INT   = 4'd8,
      OP_FROM_INT = 4'd9
   } opcode_type;

   typedef struct packed {
      logic [3:0]         opcode;
      logic signed [31:0] operand_a;
      logic signed [31:0] operand_b;
   } req_type;

   typedef struct packed {
      logic signed [31:0] result;
      logic               a_less;
      logic               a_equal;
      logic               a_greater;
      logic               div_by_zero;
   } rsp_type;

   typedef struct packed {
      logic [31:0] result;
      logic        do_div;
      logic        negate;
      logic        a_less;
      logic        a_equal;
      logic        a_greater;
      logic        div_by_zero;
   } side_type;

   typedef struct packed {
      logic signed [63:0] product;
      logic               is_mul;
      logic [31:0]        mag_a;
      logic [31:0]        mag_b;
      side_type           side;
   } mid_type;

endpackage

// ===== rtl/fpa_divider.sv =====
// ---------------------------------------------------------------------------
// Fixed-point ALU divider pipeline
// Unsigned restoring divider, one quotient bit per register stage. Keeps the
// low 32 quotient bits and carries a sideband record alongside each beat.
// ---------------------------------------------------------------------------
module fpa_divider import fpa_pkg::*; #(
   parameter int NUM_W = 40
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             en,
   input  logic             in_valid,
   input  logic [NUM_W-1:0] in_num,
   input  logic [31:0]      in_den,
   input  side_type         in_side,
   output logic             out_valid,
   output logic [31:0]      out_quo,
   output side_type         out_side
);

   logic             valid_ff [NUM_W];
   logic [NUM_W-1:0] num_ff   [NUM_W];
   logic [31:0]      rem_ff   [NUM_W];
   logic [31:0]      quo_ff   [NUM_W];
   logic [31:0]      den_ff   [NUM_W];
   side_type         side_ff  [NUM_W];

   logic             valid_src [NUM_W];
   logic [NUM_W-1:0] num_src   [NUM_W];
   logic [31:0]      rem_src   [NUM_W];
   logic [31:0]      quo_src   [NUM_W];
   logic [31:0]      den_src   [NUM_W];
   side_type         side_src  [NUM_W];

   logic [NUM_W-1:0] num_in [NUM_W];
   logic [31:0]      rem_in [NUM_W];
   logic [31:0]      quo_in [NUM_W];

   genvar k;
   generate
      for (k = 0; k < NUM_W; k++) begin : g_step
         logic [32:0] trial;
         logic        ge;

         if (k == 0) begin : g_first
            assign valid_src[k] = in_valid;
            assign num_src[k]   = in_num;
            assign rem_src[k]   = 32'd0;
            assign quo_src[k]   = 32'd0;
            assign den_src[k]   = in_den;
            assign side_src[k]  = in_side;
         end else begin : g_next
            assign valid_src[k] = valid_ff[k-1];
            assign num_src[k]   = num_ff[k-1];
            assign rem_src[k]   = rem_ff[k-1];
            assign quo_src[k]   = quo_ff[k-1];
            assign den_src[k]   = den_ff[k-1];
            assign side_src[k]  = side_ff[k-1];
         end

         assign trial     = {rem_src[k], num_src[k][NUM_W-1]};
         assign ge        = trial >= {1'b0, den_src[k]};
         assign rem_in[k] = ge ? 32'(trial - {1'b0, den_src[k]}) : trial[31:0];
         assign quo_in[k] = {quo_src[k][30:0], ge};
         assign num_in[k] = num_src[k] << 1;

         always_ff @(posedge clock) begin
            if (reset) begin
               valid_ff[k] <= 1'b0;
            end else if (en) begin
               valid_ff[k] <= valid_src[k];
            end
         end

         always_ff @(posedge clock) begin
            if (en) begin
               num_ff[k]  <= num_in[k];
               rem_ff[k]  <= rem_in[k];
               quo_ff[k]  <= quo_in[k];
               den_ff[k]  <= den_src[k];
               side_ff[k] <= side_src[k];
            end
         end
      end
   endgenerate

   assign out_valid = valid_ff[NUM_W-1];
   assign out_quo   = quo_ff[NUM_W-1];
   assign out_side  = side_ff[NUM_W-1];

endmodule

// ===== rtl/fixed_point_alu.sv =====
// ---------------------------------------------------------------------------
// Signed fixed-point ALU
// Add, subtract, multiply, divide, step, min/max and format conversions on
// 32-bit two's-complement words with FRAC_BITS fractional bits, plus signed
// compare flags of operand_a against operand_b.
// ---------------------------------------------------------------------------
// Takes one beat per clock while req_stall is low and returns one result beat
// per request, in order, on one path for every opcode: input register, operate
// stage, divider load stage, the divider (one quotient bit per pipeline stage
// across 32 + FRAC_BITS stages; default format Q24.8) and the output register.
// A two-entry output buffer lets the pipeline run after rsp_stall rises until
// a result fills the skid entry; req_stall is a registered signal.
// Divide by zero returns operand_a and raises div_by_zero. Results wrap.
module fixed_point_alu import fpa_pkg::*; #(
   parameter int FRAC_BITS = 8
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   localparam int NUM_W = 32 + FRAC_BITS;

   logic             en;
   logic             s0_valid_ff;
   req_type          s0_data_ff;
   logic             s1_valid_ff;
   mid_type          s1_data_ff;
   mid_type          s1_data_in;
   logic             s2_valid_ff;
   logic [NUM_W-1:0] s2_num_ff;
   logic [31:0]      s2_den_ff;
   side_type         s2_side_ff;
   side_type         s2_side_in;

   logic             div_valid;
   logic [31:0]      div_quo;
   side_type         div_side;
   rsp_type          fin_data;

   logic             out_valid_ff;
   rsp_type          out_data_ff;
   logic             skid_valid_ff;
   rsp_type          skid_data_ff;
   logic             take;

   logic signed [31:0] op_a;
   logic signed [31:0] op_b;
   logic [31:0]        ua;
   logic [31:0]        ub;

   assign en        = !skid_valid_ff;
   assign req_stall = skid_valid_ff;

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
      end else if (en) begin
         s0_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s0_data_ff <= req_data;
      end
   end

   // operate: product, simple results, flags, divide magnitudes
   assign op_a = s0_data_ff.operand_a;
   assign op_b = s0_data_ff.operand_b;
   assign ua   = s0_data_ff.operand_a;
   assign ub   = s0_data_ff.operand_b;

   always_comb begin
      s1_data_in = '0;
      s1_data_in.product = $signed({{32{op_a[31]}}, op_a}) * $signed({{32{op_b[31]}}, op_b});
      s1_data_in.mag_a   = op_a[31] ? (~ua + 32'd1) : ua;
      s1_data_in.mag_b   = op_b[31] ? (~ub + 32'd1) : ub;
      s1_data_in.side.negate    = op_a[31] ^ op_b[31];
      s1_data_in.side.a_less    = op_a < op_b;
      s1_data_in.side.a_equal   = op_a == op_b;
      s1_data_in.side.a_greater = op_a > op_b;
      case (s0_data_ff.opcode)
         OP_ADD:      s1_data_in.side.result = ua + ub;
         OP_SUB:      s1_data_in.side.result = ua - ub;
         OP_MUL:      s1_data_in.is_mul = 1'b1;
         OP_DIV: begin
            if (ub == 32'd0) begin
               s1_data_in.side.result      = ua;
               s1_data_in.side.div_by_zero = 1'b1;
            end else begin
               s1_data_in.side.do_div = 1'b1;
            end
         end
         OP_INC:      s1_data_in.side.result = ua + 32'd1;
         OP_DEC:      s1_data_in.side.result = ua - 32'd1;
         OP_MIN:      s1_data_in.side.result = (op_a > op_b) ? ub : ua;
         OP_MAX:      s1_data_in.side.result = (op_a < op_b) ? ub : ua;
         OP_TO_INT:   s1_data_in.side.result = 32'(op_a >>> FRAC_BITS);
         OP_FROM_INT: s1_data_in.side.result = ua << FRAC_BITS;
         default:     s1_data_in.side.result = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (en) begin
         s1_valid_ff <= s0_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_data_ff <= s1_data_in;
      end
   end

   // scale product, load divider
   always_comb begin
      s2_side_in = s1_data_ff.side;
      if (s1_data_ff.is_mul) begin
         s2_side_in.result = 32'(s1_data_ff.product >>> FRAC_BITS);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (en) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s2_num_ff  <= {s1_data_ff.mag_a, {FRAC_BITS{1'b0}}};
         s2_den_ff  <= s1_data_ff.mag_b;
         s2_side_ff <= s2_side_in;
      end
   end

   fpa_divider #(
      .NUM_W (NUM_W)
   ) u_divider (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (s2_valid_ff),
      .in_num    (s2_num_ff),
      .in_den    (s2_den_ff),
      .in_side   (s2_side_ff),
      .out_valid (div_valid),
      .out_quo   (div_quo),
      .out_side  (div_side)
   );

   // apply quotient sign, pick final result
   always_comb begin
      fin_data.result      = div_side.result;
      fin_data.a_less      = div_side.a_less;
      fin_data.a_equal     = div_side.a_equal;
      fin_data.a_greater   = div_side.a_greater;
      fin_data.div_by_zero = div_side.div_by_zero;
      if (div_side.do_div) begin
         fin_data.result = div_side.negate ? (~div_quo + 32'd1) : div_quo;
      end
   end

   // output register with skid entry
   assign take = out_valid_ff && !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (!out_valid_ff || take) begin
         if (skid_valid_ff) begin
            out_valid_ff  <= 1'b1;
            skid_valid_ff <= 1'b0;
         end else begin
            out_valid_ff <= en && div_valid;
         end
      end else if (en && div_valid) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (!out_valid_ff || take) begin
         out_data_ff <= skid_valid_ff ? skid_data_ff : fin_data;
      end else if (en && div_valid) begin
         skid_data_ff <= fin_data;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

   a_flags_onehot: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $onehot({rsp_data.a_less, rsp_data.a_equal, rsp_data.a_greater}))
      else $error("compare flags not one-hot");

   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid entry full while output empty");

   a_skid_holds: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff && rsp_stall |=> skid_valid_ff)
      else $error("skid entry dropped while stalled");

   a_div_zero_excl: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff |-> !(s1_data_ff.side.do_div && s1_data_ff.side.div_by_zero))
      else $error("divide marked both active and by zero");

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Fixed-point ALU testbench
// Sends directed corner beats and then random beats through the ALU. Both
// sides idle at random, and the result side holds off for a long stretch
// once. A local model predicts every result, and each result is compared
// field by field in arrival order.
// ---------------------------------------------------------------------------
module tb_top import fpa_pkg::*; ();

   localparam int FRAC_BITS    = 8;
   localparam int LATENCY      = 35 + FRAC_BITS;
   localparam int RANDOM_BEATS = 1280;
   localparam int CALM_FIRST   = 500;
   localparam int CALM_LAST    = 800;
   localparam int HOLD_AT      = 200;
   localparam int HOLD_CYCLES  = 200;

   localparam logic [3:0] OP_FIRST_UNUSED = 4'd10;
   localparam logic [3:0] OP_LAST_UNUSED  = 4'd15;

   localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;
   localparam logic signed [31:0] Q_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [31:0] Q_ONE = 32'sd1 <<< FRAC_BITS;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   req_type pending_req[$];
   rsp_type expected_rsp[$];
   int      fail_count    = 0;
   int      accepted_reqs = 0;
   int      received_rsps = 0;
   int      hold_left     = 0;
   bit      hold_done     = 1'b0;

   fixed_point_alu #(.FRAC_BITS(FRAC_BITS)) dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   function automatic rsp_type alu_predict(req_type beat);
      rsp_type            r;
      logic signed [31:0] a;
      logic signed [31:0] b;
      longint             wide_a;
      longint             wide_b;
      longint             wide;
      a = beat.operand_a;
      b = beat.operand_b;
      wide_a = a;
      wide_b = b;
      r = '0;
      r.a_less    = (a < b);
      r.a_equal   = (a == b);
      r.a_greater = (a > b);
      case (beat.opcode)
         OP_ADD:      r.result = a + b;
         OP_SUB:      r.result = a - b;
         OP_MUL: begin
            wide = (wide_a * wide_b) >>> FRAC_BITS;
            r.result = wide[31:0];
         end
         OP_DIV: begin
            if (b == 0) begin
               r.result      = a;
               r.div_by_zero = 1'b1;
            end else begin
               wide = (wide_a <<< FRAC_BITS) / wide_b;
               r.result = wide[31:0];
            end
         end
         OP_INC:      r.result = a + 32'sd1;
         OP_DEC:      r.result = a - 32'sd1;
         OP_MIN:      r.result = (a > b) ? b : a;
         OP_MAX:      r.result = (a < b) ? b : a;
         OP_TO_INT:   r.result = a >>> FRAC_BITS;
         OP_FROM_INT: r.result = a << FRAC_BITS;
         default:     r.result = '0;
      endcase
      return r;
   endfunction

   function automatic bit idle_now(int beats);
      return ($urandom_range(99) < 12) && (beats < CALM_FIRST || beats >= CALM_LAST);
   endfunction

   function automatic logic signed [31:0] random_operand();
      logic signed [31:0] corner[7];
      corner = '{Q_MIN, Q_MAX, 32'sd0, -32'sd1, 32'sd1, Q_ONE, -Q_ONE};
      case ($urandom_range(3))
         0, 1:    return $urandom;
         2:       return $signed($urandom_range(8191)) - 32'sd4096;
         default: return corner[$urandom_range(6)];
      endcase
   endfunction

   task automatic queue_beat(logic [3:0] op, logic signed [31:0] a, logic signed [31:0] b);
      req_type beat;
      beat.opcode    = op;
      beat.operand_a = a;
      beat.operand_b = b;
      pending_req.push_back(beat);
   endtask

   task automatic queue_random_beat();
      logic [3:0]         op;
      logic signed [31:0] a;
      logic signed [31:0] b;
      if ($urandom_range(99) < 8)
         op = 4'($urandom_range(int'(OP_LAST_UNUSED), int'(OP_FIRST_UNUSED)));
      else
         op = 4'($urandom_range(int'(OP_FROM_INT), int'(OP_ADD)));
      a = random_operand();
      b = random_operand();
      if ($urandom_range(9) == 0)
         b = a;
      else if (op == OP_DIV && $urandom_range(9) == 0)
         b = '0;
      queue_beat(op, a, b);
   endtask

   task automatic report_mismatch(string what);
      $display("ERROR at %0t: %s", $time, what);
      fail_count++;
   endtask

   task automatic check_rsp(rsp_type got);
      rsp_type want;
      if (expected_rsp.size() == 0) begin
         report_mismatch($sformatf("result beat with none outstanding: %h", got));
         return;
      end
      want = expected_rsp.pop_front();
      if (got.result !== want.result)
         report_mismatch($sformatf("result %h, want %h", got.result, want.result));
      if (got.a_less !== want.a_less)
         report_mismatch($sformatf("a_less %b, want %b", got.a_less, want.a_less));
      if (got.a_equal !== want.a_equal)
         report_mismatch($sformatf("a_equal %b, want %b", got.a_equal, want.a_equal));
      if (got.a_greater !== want.a_greater)
         report_mismatch($sformatf("a_greater %b, want %b", got.a_greater, want.a_greater));
      if (got.div_by_zero !== want.div_by_zero)
         report_mismatch($sformatf("div_by_zero %b, want %b",
                                   got.div_by_zero, want.div_by_zero));
   endtask

   initial begin
      forever #10 clock = ~clock;
   end

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            expected_rsp.push_back(alu_predict(req_data));
            accepted_reqs++;
         end
         if (!req_valid || !req_stall) begin
            if (pending_req.size() != 0 && !idle_now(accepted_reqs)) begin
               req_valid <= 1'b1;
               req_data  <= pending_req.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // result monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            check_rsp(rsp_data);
            received_rsps++;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (!hold_done && received_rsps >= HOLD_AT) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= idle_now(received_rsps);
         end
      end
   end

   initial begin
      queue_beat(OP_ADD, Q_MAX, 32'sd1);
      queue_beat(OP_ADD, 32'sd0, -32'sd1);
      queue_beat(OP_SUB, Q_MIN, 32'sd1);
      queue_beat(OP_MUL, 32'sd384, 32'sd512);
      queue_beat(OP_MUL, Q_MIN, Q_MIN);
      queue_beat(OP_MUL, -32'sd1, 32'sd1);
      queue_beat(OP_MUL, Q_MAX, Q_MAX);
      queue_beat(OP_DIV, Q_ONE, 32'sd768);
      queue_beat(OP_DIV, -Q_ONE, 32'sd768);
      queue_beat(OP_DIV, 32'sd12345, 32'sd0);
      queue_beat(OP_DIV, 32'sd0, 32'sd0);
      queue_beat(OP_DIV, Q_MIN, -32'sd1);
      queue_beat(OP_DIV, Q_MAX, 32'sd1);
      queue_beat(OP_INC, Q_MAX, Q_MIN);
      queue_beat(OP_DEC, Q_MIN, Q_MAX);
      queue_beat(OP_MIN, Q_MIN, Q_MAX);
      queue_beat(OP_MAX, Q_MIN, Q_MAX);
      queue_beat(OP_MIN, -32'sd5, -32'sd5);
      queue_beat(OP_TO_INT, -32'sd1, 32'sd0);
      queue_beat(OP_TO_INT, Q_MAX, Q_MAX);
      queue_beat(OP_FROM_INT, Q_MAX, 32'sd0);
      queue_beat(OP_FROM_INT, Q_MIN, -32'sd1);
      queue_beat(OP_FIRST_UNUSED, 32'sd7, 32'sd3);
      queue_beat(OP_LAST_UNUSED, -32'sd1, 32'sd1);
      repeat (RANDOM_BEATS) queue_random_beat();

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      while (pending_req.size() != 0 || req_valid || expected_rsp.size() != 0)
         @(posedge clock);
      repeat (2 * LATENCY) @(posedge clock);

      if (fail_count == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

   initial begin
      #2_000_000;
      $display("== FAIL ==");
      $finish;
   end

endmodule
